// ----- rtl/bsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

    localparam int RAW_W      = 24;
    localparam int TEMP_W     = 16;
    localparam int PRESS_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_TEMP_WORDS = 8'd0,
        REG_CAL_PRESS_BASE = 8'd1,
        REG_CAL_PRESS_MID  = 8'd2,
        REG_CAL_PRESS_HIGH = 8'd3
    } cfg_index_t;

    // Scale and offset applied to each raw 16-bit calibration field.
    localparam longint A1_MUL  = 3608;
    localparam longint A1_OFS  = -1731677965;
    localparam longint A2_MUL  = 16889;
    localparam longint A2_OFS  = -87619360;
    localparam longint BT1_MUL = 2982;
    localparam longint BT1_OFS = 107370906;
    localparam longint BT2_MUL = 329854;
    localparam longint BT2_OFS = 108083093;
    localparam longint BP1_MUL = 19923;
    localparam longint BP1_OFS = 1133836764;
    localparam longint B11_MUL = 2406;
    localparam longint B11_OFS = 118215883;
    localparam longint BP2_MUL = 3079;
    localparam longint BP2_OFS = -181579595;
    localparam longint B12_MUL = 6846;
    localparam longint B12_OFS = 85590281;
    localparam longint B21_MUL = 13836;
    localparam longint B21_OFS = 79333336;
    localparam longint BP3_MUL = 2915;
    localparam longint BP3_OFS = 157155561;

endpackage

`default_nettype wire

// ----- rtl/bsc_sample_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bsc_sample_if;
    logic                       valid;
    logic                       ready;
    logic [bsc_pkg::RAW_W-1:0]  raw_temperature;
    logic [bsc_pkg::RAW_W-1:0]  raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

`default_nettype wire

// ----- rtl/bsc_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bsc_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [bsc_pkg::TEMP_W-1:0]  temperature_comp;
    logic signed [bsc_pkg::PRESS_W-1:0] pressure_q4;

    modport source (output valid, output temperature_comp, output pressure_q4, input ready);
    modport sink   (input valid, input temperature_comp, input pressure_q4, output ready);
endinterface

`default_nettype wire

// ----- rtl/bsc_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bsc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bsc_pkg::CFG_IDX_W-1:0]   index;
    logic [bsc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bsc_div32767.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Signed 64-bit division by 32767, truncating toward zero, three register stages.
module bsc_div32767
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [63:0] x,
    output logic signed [63:0]      q
);

    logic        neg_a_reg;
    logic [63:0] mag_a_reg;
    logic        neg_b_reg;
    logic [18:0] mag_b_reg;
    logic [63:0] q0_b_reg;
    logic signed [63:0] q_c_reg;

    logic [63:0] mag_next;
    logic [63:0] q0_next;
    logic [18:0] rem;
    logic [18:0] corr;
    logic [63:0] qm;
    logic signed [63:0] q_next;

    always_comb
    begin
        mag_next = x[63] ? (64'd0 - x) : x;
        // Since 2^15 = 32767 + 1, n / 32767 is the sum of n / 2^(15k); the
        // floors of the first four terms fall short by less than five.
        q0_next = (mag_a_reg >> 15) + (mag_a_reg >> 30) + (mag_a_reg >> 45)
                + (mag_a_reg >> 60);
        rem  = mag_b_reg - {q0_b_reg[3:0], 15'd0} + q0_b_reg[18:0];
        corr = (rem + (rem >> 15) + 19'd1) >> 15;
        qm   = q0_b_reg + 64'(corr);
        q_next = neg_b_reg ? (64'sd0 - $signed(qm)) : $signed(qm);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= x[63];
            mag_a_reg <= mag_next;
            neg_b_reg <= neg_a_reg;
            mag_b_reg <= mag_a_reg[18:0];
            q0_b_reg  <= q0_next;
            q_c_reg   <= q_next;
        end
    end

    assign q = q_c_reg;

endmodule

`default_nettype wire

// ----- rtl/baro_sensor_compensation_core.sv -----
// Barometric sensor compensation core.
// Each request on the sample channel carries one raw 24-bit temperature and
// one raw 24-bit pressure conversion. For every request one result leaves on
// the result channel: the compensated temperature (signed 16 bits) and the
// pressure in pascals with four fraction bits (signed 32 bits).
// The cfg channel writes the four packed calibration registers; it is always
// ready, and derived coefficients are computed as the write is taken.
// The user must write registers only while no request is in flight; the
// core does not enforce this. Throughput is one request per clock while
// the result channel does not stall. From acceptance to the result being
// valid there are fifteen pipeline stages, set by the chain of dependent
// multiplies and the two three-stage dividers by 32767, plus the output
// register. Reset clears all valid flags and sets the calibration to the
// values of all-zero register contents. When the receiver stalls, one more
// result is caught in a skid register; the pipeline then holds and
// sample.ready drops until the skid drains. Nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module baro_sensor_compensation_core
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    bsc_sample_if.sink    sample,
    bsc_result_if.source  result,
    bsc_cfg_if.sink       cfg
);

    localparam int NSTAGE = 15;

    function automatic logic signed [47:0] scale16(logic signed [15:0] f, longint m,
                                                   longint o);
        return 48'(f) * 48'(m) + 48'(o);
    endfunction

    // ---------------- calibration ----------------
    logic signed [19:0] a0_reg, b00_reg;
    logic signed [31:0] a1_reg, a2_reg, bt1_reg, bp1_reg, b11_reg, bp2_reg;
    logic signed [31:0] b12_reg, b21_reg, bp3_reg;
    logic signed [35:0] bt2_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_reg  <= '0;
            a1_reg  <= 32'(bsc_pkg::A1_OFS);
            a2_reg  <= 32'(bsc_pkg::A2_OFS);
            b00_reg <= '0;
            bt1_reg <= 32'(bsc_pkg::BT1_OFS);
            bt2_reg <= 36'(bsc_pkg::BT2_OFS);
            bp1_reg <= 32'(bsc_pkg::BP1_OFS);
            b11_reg <= 32'(bsc_pkg::B11_OFS);
            bp2_reg <= 32'(bsc_pkg::BP2_OFS);
            b12_reg <= 32'(bsc_pkg::B12_OFS);
            b21_reg <= 32'(bsc_pkg::B21_OFS);
            bp3_reg <= 32'(bsc_pkg::BP3_OFS);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                bsc_pkg::REG_CAL_TEMP_WORDS:
                begin
                    a0_reg <= cfg.data[19:0];
                    a1_reg <= 32'(scale16(cfg.data[35:20], bsc_pkg::A1_MUL, bsc_pkg::A1_OFS));
                    a2_reg <= 32'(scale16(cfg.data[51:36], bsc_pkg::A2_MUL, bsc_pkg::A2_OFS));
                end
                bsc_pkg::REG_CAL_PRESS_BASE:
                begin
                    b00_reg <= cfg.data[19:0];
                    bt1_reg <= 32'(scale16(cfg.data[35:20], bsc_pkg::BT1_MUL,
                                           bsc_pkg::BT1_OFS));
                    bt2_reg <= 36'(scale16(cfg.data[51:36], bsc_pkg::BT2_MUL,
                                           bsc_pkg::BT2_OFS));
                end
                bsc_pkg::REG_CAL_PRESS_MID:
                begin
                    bp1_reg <= 32'(scale16(cfg.data[15:0], bsc_pkg::BP1_MUL,
                                           bsc_pkg::BP1_OFS));
                    b11_reg <= 32'(scale16(cfg.data[31:16], bsc_pkg::B11_MUL,
                                           bsc_pkg::B11_OFS));
                    bp2_reg <= 32'(scale16(cfg.data[47:32], bsc_pkg::BP2_MUL,
                                           bsc_pkg::BP2_OFS));
                    b12_reg <= 32'(scale16(cfg.data[63:48], bsc_pkg::B12_MUL,
                                           bsc_pkg::B12_OFS));
                end
                bsc_pkg::REG_CAL_PRESS_HIGH:
                begin
                    b21_reg <= 32'(scale16(cfg.data[15:0], bsc_pkg::B21_MUL,
                                           bsc_pkg::B21_OFS));
                    bp3_reg <= 32'(scale16(cfg.data[31:16], bsc_pkg::BP3_MUL,
                                           bsc_pkg::BP3_OFS));
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic              en;
    logic [NSTAGE-1:0] vld_reg;
    logic              skid_vld_reg;
    logic              out_vld_reg;

    assign en           = ~skid_vld_reg;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTAGE-2:0], sample.valid};
    end

    // ---------------- stage 1 ----------------
    logic signed [23:0] dt_in, dp_in;
    logic signed [55:0] ma1_next, ma2_full, pbp1_full, pbp2_full, pbp3_full;
    logic signed [23:0] s1_dt_reg, s1_dp_reg;
    logic signed [55:0] s1_ma1_reg;
    logic signed [41:0] s1_ma2_reg;
    logic signed [50:0] s1_pbp1_reg;
    logic signed [42:0] s1_pbp2_reg;
    logic signed [43:0] s1_pbp3_reg;

    always_comb
    begin
        // Subtracting 2^23 from a 24-bit value flips its top bit.
        dt_in = {~sample.raw_temperature[23], sample.raw_temperature[22:0]};
        dp_in = {~sample.raw_pressure[23], sample.raw_pressure[22:0]};
        ma1_next  = 56'(a1_reg) * 56'(dt_in);
        ma2_full  = 56'(a2_reg) * 56'(dt_in);
        pbp1_full = 56'(bp1_reg) * 56'(dp_in);
        pbp2_full = 56'(bp2_reg) * 56'(dp_in);
        pbp3_full = 56'(bp3_reg) * 56'(dp_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dt_reg   <= dt_in;
            s1_dp_reg   <= dp_in;
            s1_ma1_reg  <= ma1_next;
            s1_ma2_reg  <= ma2_full[55:14];
            s1_pbp1_reg <= pbp1_full[55:5];
            s1_pbp2_reg <= pbp2_full[55:13];
            s1_pbp3_reg <= pbp3_full[55:12];
        end
    end

    // ---------------- stage 2 ----------------
    logic signed [63:0] tw2_full, pbp2b_full, pbp3b_full;
    logic signed [53:0] s2_tw2_reg;
    logic signed [62:0] s2_pbp2_reg;
    logic signed [40:0] s2_pbp3_reg;
    logic signed [55:0] s2_ma1_reg;
    logic signed [50:0] s2_pbp1_reg;
    logic signed [23:0] s2_dp_reg;

    always_comb
    begin
        tw2_full   = 64'(s1_ma2_reg) * 64'(s1_dt_reg);
        pbp2b_full = 64'(s1_pbp2_reg) * 64'(s1_dp_reg);
        pbp3b_full = 64'(s1_pbp3_reg) * 64'(s1_dp_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_tw2_reg  <= tw2_full[63:10];
            s2_pbp2_reg <= pbp2b_full[63:1];
            s2_pbp3_reg <= pbp3b_full[63:23];
            s2_ma1_reg  <= s1_ma1_reg;
            s2_pbp1_reg <= s1_pbp1_reg;
            s2_dp_reg   <= s1_dp_reg;
        end
    end

    // ---------------- stage 3 ----------------
    logic signed [63:0] s3_tsum_reg, s3_pbp3_reg;
    logic signed [50:0] s3_pbp1_reg;
    logic signed [62:0] s3_pbp2_reg;
    logic signed [23:0] s3_dp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_tsum_reg <= 64'(s2_ma1_reg) + 64'(s2_tw2_reg);
            s3_pbp3_reg <= 64'(s2_pbp3_reg) * 64'(s2_dp_reg);
            s3_pbp1_reg <= s2_pbp1_reg;
            s3_pbp2_reg <= s2_pbp2_reg;
            s3_dp_reg   <= s2_dp_reg;
        end
    end

    // ---------------- stages 4-6: temperature division ----------------
    logic signed [63:0] tq;
    logic signed [50:0] d1_pbp1_reg [3];
    logic signed [62:0] d1_pbp2_reg [3];
    logic signed [63:0] d1_pbp3_reg [3];
    logic signed [23:0] d1_dp_reg   [3];

    bsc_div32767 u_div_temp
    (
        .clk (clk),
        .en  (en),
        .x   (s3_tsum_reg),
        .q   (tq)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_pbp1_reg[0] <= s3_pbp1_reg;
            d1_pbp2_reg[0] <= s3_pbp2_reg;
            d1_pbp3_reg[0] <= s3_pbp3_reg;
            d1_dp_reg[0]   <= s3_dp_reg;
            for (int i = 1; i < 3; i++)
            begin
                d1_pbp1_reg[i] <= d1_pbp1_reg[i-1];
                d1_pbp2_reg[i] <= d1_pbp2_reg[i-1];
                d1_pbp3_reg[i] <= d1_pbp3_reg[i-1];
                d1_dp_reg[i]   <= d1_dp_reg[i-1];
            end
        end
    end

    // ---------------- stage 7: temperature ----------------
    logic signed [63:0] tsum2;
    logic signed [15:0] s7_tx_reg;
    logic signed [50:0] s7_pbp1_reg;
    logic signed [62:0] s7_pbp2_reg;
    logic signed [63:0] s7_pbp3_reg;
    logic signed [23:0] s7_dp_reg;

    assign tsum2 = 64'(a0_reg) + (tq >>> 19);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_tx_reg   <= tsum2[19:4];
            s7_pbp1_reg <= d1_pbp1_reg[2];
            s7_pbp2_reg <= d1_pbp2_reg[2];
            s7_pbp3_reg <= d1_pbp3_reg[2];
            s7_dp_reg   <= d1_dp_reg[2];
        end
    end

    // ---------------- stage 8: coefficient times temperature ----------------
    logic signed [47:0] bt1t_full, b11t_full, b12t_full, b21t_full;
    logic signed [51:0] bt2t_full;
    logic signed [47:0] s8_bt1_reg, s8_b12_reg;
    logic signed [50:0] s8_bt2_reg;
    logic signed [43:0] s8_b11_reg;
    logic signed [41:0] s8_b21_reg;
    logic signed [15:0] s8_tx_reg;
    logic signed [50:0] s8_pbp1_reg;
    logic signed [62:0] s8_pbp2_reg;
    logic signed [63:0] s8_pbp3_reg;
    logic signed [23:0] s8_dp_reg;

    always_comb
    begin
        bt1t_full = 48'(bt1_reg) * 48'(s7_tx_reg);
        bt2t_full = 52'(bt2_reg) * 52'(s7_tx_reg);
        b11t_full = 48'(b11_reg) * 48'(s7_tx_reg);
        b12t_full = 48'(b12_reg) * 48'(s7_tx_reg);
        b21t_full = 48'(b21_reg) * 48'(s7_tx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_bt1_reg  <= bt1t_full;
            s8_bt2_reg  <= bt2t_full[51:1];
            s8_b11_reg  <= b11t_full[47:4];
            s8_b12_reg  <= b12t_full;
            s8_b21_reg  <= b21t_full[47:6];
            s8_tx_reg   <= s7_tx_reg;
            s8_pbp1_reg <= s7_pbp1_reg;
            s8_pbp2_reg <= s7_pbp2_reg;
            s8_pbp3_reg <= s7_pbp3_reg;
            s8_dp_reg   <= s7_dp_reg;
        end
    end

    // ---------------- stage 9 ----------------
    logic signed [63:0] x1_full, x2_full, x3_full, x4_full;
    logic signed [55:0] s9_x1_reg;
    logic signed [62:0] s9_x2_reg;
    logic signed [41:0] s9_x3_reg;
    logic signed [40:0] s9_x4_reg;
    logic signed [63:0] s9_w1_reg;
    logic signed [15:0] s9_tx_reg;
    logic signed [62:0] s9_pbp2_reg;
    logic signed [63:0] s9_pbp3_reg;
    logic signed [23:0] s9_dp_reg;

    always_comb
    begin
        x1_full = 64'(s8_bt2_reg) * 64'(s8_tx_reg);
        x2_full = 64'(s8_b11_reg) * 64'(s8_dp_reg);
        x3_full = 64'(s8_b12_reg) * 64'(s8_tx_reg);
        x4_full = 64'(s8_b21_reg) * 64'(s8_dp_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_x1_reg   <= x1_full[63:8];
            s9_x2_reg   <= x2_full[63:1];
            s9_x3_reg   <= x3_full[63:22];
            s9_x4_reg   <= x4_full[63:23];
            s9_w1_reg   <= 64'(s8_bt1_reg) + 64'(s8_pbp1_reg);
            s9_tx_reg   <= s8_tx_reg;
            s9_pbp2_reg <= s8_pbp2_reg;
            s9_pbp3_reg <= s8_pbp3_reg;
            s9_dp_reg   <= s8_dp_reg;
        end
    end

    // ---------------- stage 10 ----------------
    logic signed [63:0] y1_full, y2_full;
    logic signed [63:0] s10_w3a_reg, s10_w1_reg, s10_pbp3_reg;
    logic signed [62:0] s10_y1_reg, s10_y2_reg;
    logic signed [15:0] s10_tx_reg;

    always_comb
    begin
        y1_full = 64'(s9_x3_reg) * 64'(s9_dp_reg);
        y2_full = 64'(s9_x4_reg) * 64'(s9_dp_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_w3a_reg  <= 64'(s9_x1_reg) + 64'(s9_x2_reg) + 64'(s9_pbp2_reg);
            s10_y1_reg   <= y1_full[63:1];
            s10_y2_reg   <= y2_full[63:1];
            s10_w1_reg   <= s9_w1_reg;
            s10_pbp3_reg <= s9_pbp3_reg;
            s10_tx_reg   <= s9_tx_reg;
        end
    end

    // ---------------- stages 11-12 ----------------
    logic signed [63:0] s11_w1_reg, s11_w3b_reg, s12_n_reg;
    logic signed [15:0] s11_tx_reg, s12_tx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_w1_reg  <= s10_w1_reg + (s10_w3a_reg >>> 14);
            s11_w3b_reg <= 64'(s10_y1_reg) + 64'(s10_y2_reg) + s10_pbp3_reg;
            s11_tx_reg  <= s10_tx_reg;
            s12_n_reg   <= s11_w1_reg + (s11_w3b_reg >>> 15);
            s12_tx_reg  <= s11_tx_reg;
        end
    end

    // ---------------- stages 13-15: pressure division ----------------
    logic signed [63:0] pq;
    logic signed [15:0] d2_tx_reg [3];

    bsc_div32767 u_div_press
    (
        .clk (clk),
        .en  (en),
        .x   (s12_n_reg),
        .q   (pq)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_tx_reg[0] <= s12_tx_reg;
            for (int i = 1; i < 3; i++)
                d2_tx_reg[i] <= d2_tx_reg[i-1];
        end
    end

    // ---------------- output register and skid ----------------
    logic signed [63:0] press_full;
    logic signed [15:0] out_temp_reg, skid_temp_reg;
    logic signed [31:0] out_press_reg, skid_press_reg;

    assign press_full = (pq >>> 11) + 64'(b00_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || result.ready)
        begin
            out_vld_reg  <= skid_vld_reg | vld_reg[NSTAGE-1];
            skid_vld_reg <= 1'b0;
        end
        else if (vld_reg[NSTAGE-1] && en)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || result.ready)
        begin
            if (skid_vld_reg)
            begin
                out_temp_reg  <= skid_temp_reg;
                out_press_reg <= skid_press_reg;
            end
            else
            begin
                out_temp_reg  <= d2_tx_reg[2];
                out_press_reg <= press_full[31:0];
            end
        end
        else if (en)
        begin
            skid_temp_reg  <= d2_tx_reg[2];
            skid_press_reg <= press_full[31:0];
        end
    end

    assign result.valid            = out_vld_reg;
    assign result.temperature_comp = out_temp_reg;
    assign result.pressure_q4      = out_press_reg;

endmodule

`default_nettype wire
